[sv/pcts_pkg.sv]
// Shared types and constants for the packed cell type store.
// No dependencies; every other file imports this package.
package pcts_pkg;

    localparam int MAX_CELLS     = 4096;
    localparam int TYPE_BITS     = 3;
    localparam int COORD_W       = 12;
    localparam int DIM_W         = 13;
    localparam int CELL_IDX_W    = $clog2(MAX_CELLS);
    localparam int PROD_W        = COORD_W + DIM_W;
    localparam int SUM_W         = PROD_W + 1;

    // The store is held as rows of several cells, each row with its own valid bit.
    localparam int CELLS_PER_ROW = 16;
    localparam int SLOT_W        = $clog2(CELLS_PER_ROW);
    localparam int ROW_BITS      = CELLS_PER_ROW * TYPE_BITS;
    localparam int ROW_OFF_W     = $clog2(ROW_BITS);
    localparam int NUM_ROWS      = MAX_CELLS / CELLS_PER_ROW;
    localparam int ROW_IDX_W     = CELL_IDX_W - SLOT_W;

    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic [DIM_W-1:0]     GRID_WIDTH_RST  = DIM_W'(64);
    localparam logic [DIM_W-1:0]     GRID_HEIGHT_RST = DIM_W'(64);
    localparam logic [TYPE_BITS-1:0] WALL_TYPE       = 3'h7;

    // Register indexes, taken from paddr[2].
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic                  func;
        logic [CELL_IDX_W-1:0] idx;
        logic [TYPE_BITS-1:0]  new_type;
        logic                  in_bounds;
    } t_cmd;

endpackage

[sv/pcts_if.sv]
// Handshake interfaces for the command and response channels.
// Depends on pcts_pkg for the field widths.
interface pcts_cmd_if import pcts_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [COORD_W-1:0]   cell_x;
    logic [COORD_W-1:0]   cell_y;
    logic [TYPE_BITS-1:0] new_type;

    modport source (output valid, func, cell_x, cell_y, new_type, input ready);
    modport sink   (input valid, func, cell_x, cell_y, new_type, output ready);
endinterface

interface pcts_rsp_if import pcts_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [TYPE_BITS-1:0] cell_type;
    logic                 passable;
    logic                 wall;
    logic                 water;
    logic                 quicksand;
    logic                 in_bounds;

    modport source (output valid, cell_type, passable, wall, water, quicksand, in_bounds,
                    input ready);
    modport sink   (input valid, cell_type, passable, wall, water, quicksand, in_bounds,
                    output ready);
endinterface

[sv/packed_cell_type_store.sv]
// Top level of the packed cell type store: front end, command queue and back end.
// Depends on pcts_pkg, pcts_if, pcts_front, pcts_queue and pcts_back.
//
//   Channel   Direction  Handshake          Word
//   i_cmd     in         valid/ready        func, cell_x, cell_y, new_type
//   o_rsp     out        valid/ready        cell_type and four flags, in_bounds
//   APB       in/out     psel/penable       grid_width at 0x0, grid_height at 0x4
//
// Each command word passes two back-end states: idle reads its row from the row
// memory; look updates the row, loads the result register and holds while a result
// waits, and only then is a new word taken. The front end turns the cell
// coordinates into a linear index and a bounds flag in the cycle it accepts a
// word, and a two-word queue lets it keep accepting while a result waits.
// Reset clears the per-row valid bits at once, so every cell reads as wall
// right after reset with no clearing pass.
module packed_cell_type_store import pcts_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pcts_cmd_if.sink              i_cmd,
    pcts_rsp_if.source            o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_cmd front_cmd;
    t_cmd q_cmd;

    // Register writes always complete in the access cycle.
    assign pready = 1'b1;

    // Classify each word: bounds test against the grid and linear cell index.
    pcts_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (front_cmd)
    );

    // Decouples acceptance from the store so each side can stall on its own.
    pcts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Carries out the read or the read-modify-write and holds the result word.
    pcts_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (q_pop),
        .o_rsp     (o_rsp)
    );

endmodule

[sv/pcts_front.sv]
// Front end: configuration registers, command acceptance and bounds/index check.
// Depends on pcts_pkg and pcts_cmd_if.
module pcts_front import pcts_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pcts_cmd_if.sink              i_cmd,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    logic [DIM_W-1:0]  r_grid_width;
    logic [DIM_W-1:0]  r_grid_height;
    logic              cfg_wr;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  lin_idx;

    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_WIDTH_RST;
            r_grid_height <= GRID_HEIGHT_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_GRID_WIDTH:  r_grid_width  <= pwdata[DIM_W-1:0];
                REG_GRID_HEIGHT: r_grid_height <= pwdata[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_GRID_WIDTH:  prdata = APB_DATA_W'(r_grid_width);
            REG_GRID_HEIGHT: prdata = APB_DATA_W'(r_grid_height);
            default:         prdata = '0;
        endcase
    end

    assign i_cmd.ready = !i_q_full;
    assign o_push      = i_cmd.valid && !i_q_full;

    // Linear cell index; a cell beyond capacity is treated as outside the grid.
    assign prod    = PROD_W'(i_cmd.cell_y) * PROD_W'(r_grid_width);
    assign lin_idx = SUM_W'(prod) + SUM_W'(i_cmd.cell_x);

    always_comb begin
        o_cmd.func      = i_cmd.func;
        o_cmd.idx       = lin_idx[CELL_IDX_W-1:0];
        o_cmd.new_type  = i_cmd.new_type;
        o_cmd.in_bounds = (DIM_W'(i_cmd.cell_x) < r_grid_width)
                       && (DIM_W'(i_cmd.cell_y) < r_grid_height)
                       && (lin_idx < SUM_W'(MAX_CELLS));
    end

endmodule

[sv/pcts_queue.sv]
// Short command queue between the front end and the store back end.
// Depends on pcts_pkg for the command struct and depth.
module pcts_queue import pcts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[sv/pcts_back.sv]
// Back end: row memory with per-row valid bits, read-modify-write and result register.
// Depends on pcts_pkg and pcts_rsp_if.
module pcts_back import pcts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cmd        i_q_cmd,
    output logic        o_pop,
    pcts_rsp_if.source  o_rsp
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOOK = 1'b1;

    logic [ROW_BITS-1:0]  r_mem [NUM_ROWS];
    logic [NUM_ROWS-1:0]  r_row_valid;
    logic                 r_state;
    logic                 n_state;
    t_cmd                 r_cmd;
    logic [ROW_BITS-1:0]  r_rd_data;
    logic                 r_rd_ok;

    logic                 r_out_valid;
    logic [TYPE_BITS-1:0] r_out_type;
    logic                 r_out_inb;

    logic [ROW_IDX_W-1:0] cmd_row;
    logic [SLOT_W-1:0]    cmd_slot;
    logic [ROW_OFF_W-1:0] bit_off;
    logic [ROW_BITS-1:0]  cur_row;
    logic [ROW_BITS-1:0]  n_row;
    logic [TYPE_BITS-1:0] n_type;
    logic                 finish;
    logic                 wr_en;

    assign o_pop    = (r_state == S_IDLE) && i_q_valid;
    assign finish   = (r_state == S_LOOK) && (!r_out_valid || o_rsp.ready);
    assign cmd_row  = r_cmd.idx[CELL_IDX_W-1:SLOT_W];
    assign cmd_slot = r_cmd.idx[SLOT_W-1:0];
    assign bit_off  = ROW_OFF_W'({cmd_slot, 1'b0}) + ROW_OFF_W'(cmd_slot);
    assign wr_en    = finish && r_cmd.in_bounds && (r_cmd.func == FUNC_WRITE);

    // A row never written reads as all walls.
    always_comb begin
        cur_row = r_rd_ok ? r_rd_data : '1;
        n_row   = cur_row;
        n_row[bit_off +: TYPE_BITS] = r_cmd.new_type;
        if (!r_cmd.in_bounds) begin
            n_type = WALL_TYPE;
        end else if (r_cmd.func == FUNC_WRITE) begin
            n_type = r_cmd.new_type;
        end else begin
            n_type = cur_row[bit_off +: TYPE_BITS];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_q_valid) n_state = S_LOOK;
            S_LOOK: if (finish) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_data <= r_mem[i_q_cmd.idx[CELL_IDX_W-1:SLOT_W]];
        end
        if (wr_en) begin
            r_mem[cmd_row] <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_row_valid[cmd_row] <= 1'b1;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd   <= i_q_cmd;
            r_rd_ok <= r_row_valid[i_q_cmd.idx[CELL_IDX_W-1:SLOT_W]];
        end
        if (finish) begin
            r_out_type <= n_type;
            r_out_inb  <= r_cmd.in_bounds;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.cell_type = r_out_type;
    assign o_rsp.passable  = !r_out_type[2];
    assign o_rsp.wall      = (r_out_type == WALL_TYPE);
    assign o_rsp.water     = (r_out_type[1:0] == 2'd1);
    assign o_rsp.quicksand = (r_out_type[1:0] == 2'd2);
    assign o_rsp.in_bounds = r_out_inb;

endmodule

[tb/pcts_tb_pkg.sv]
// Cell map tracker for the packed cell type store testbench: it keeps its own grid of
// cell types, works out the response word of every accepted command and checks it.
// Depends on pcts_pkg for widths, codes and reset values.
package pcts_tb_pkg;
    import pcts_pkg::*;

    typedef struct packed {
        logic [TYPE_BITS-1:0] cell_type;
        logic                 passable;
        logic                 wall;
        logic                 water;
        logic                 quicksand;
        logic                 in_bounds;
    } t_cell_result;

    class t_cell_map_tracker;
        logic [TYPE_BITS-1:0] cell_types [MAX_CELLS];
        int unsigned          grid_w;
        int unsigned          grid_h;
        t_cell_result         pending_cells [$];
        int unsigned          errors;

        function new();
            foreach (cell_types[i]) cell_types[i] = WALL_TYPE;
            grid_w = GRID_WIDTH_RST;
            grid_h = GRID_HEIGHT_RST;
            errors = 0;
        endfunction

        function void set_dimension(logic reg_sel, logic [APB_DATA_W-1:0] value);
            if (reg_sel == REG_GRID_WIDTH) begin
                grid_w = value[DIM_W-1:0];
            end else begin
                grid_h = value[DIM_W-1:0];
            end
        endfunction

        // Applies one accepted command word to the map and queues the response it yields.
        function void take_command(logic func, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                   logic [TYPE_BITS-1:0] new_type);
            int unsigned          idx;
            bit                   inb;
            logic [TYPE_BITS-1:0] ct;
            t_cell_result         r;
            idx = x + y * grid_w;
            inb = (x < grid_w) && (y < grid_h) && (idx < MAX_CELLS);
            if (inb) begin
                if (func == FUNC_WRITE) cell_types[idx] = new_type;
                ct = cell_types[idx];
            end else begin
                ct = WALL_TYPE;
            end
            r.cell_type = ct;
            r.passable  = ~ct[2];
            r.wall      = (ct == WALL_TYPE);
            r.water     = (ct[1:0] == 2'd1);
            r.quicksand = (ct[1:0] == 2'd2);
            r.in_bounds = inb;
            pending_cells.push_back(r);
        endfunction

        function void compare_field(string name, logic [TYPE_BITS-1:0] want,
                                    logic [TYPE_BITS-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_response(t_cell_result got);
            t_cell_result want;
            if (pending_cells.size() == 0) begin
                $error("response word with no command waiting for it");
                errors++;
                return;
            end
            want = pending_cells.pop_front();
            compare_field("cell_type", want.cell_type, got.cell_type);
            compare_field("passable",  want.passable,  got.passable);
            compare_field("wall",      want.wall,      got.wall);
            compare_field("water",     want.water,     got.water);
            compare_field("quicksand", want.quicksand, got.quicksand);
            compare_field("in_bounds", want.in_bounds, got.in_bounds);
        endfunction

        function int unsigned outstanding();
            return pending_cells.size();
        endfunction
    endclass

endpackage

[tb/packed_cell_type_store_tb.sv]
// Top of the packed cell type store testbench: clock, reset, command and response
// drivers, APB grid setup and the final verdict.
// Depends on pcts_pkg, pcts_if, pcts_tb_pkg and the block itself.
module packed_cell_type_store_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pcts_pkg::*;
    import pcts_tb_pkg::*;

    // The watchdog counts cycles in which no word moves on any port. The random stalls
    // are far shorter than QUIET_LIMIT, so a quiet stretch of this length can only mean
    // the block has hung.
    localparam int QUIET_LIMIT    = 2000;
    localparam int PHASE_ITEMS    = 85;
    localparam int NUM_PHASES     = 12;
    localparam int RECENT_CELLS   = 32;
    localparam int DRAIN_CYCLES   = 20;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pcts_cmd_if cmd_if ();
    pcts_rsp_if rsp_if ();

    packed_cell_type_store dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_cell_map_tracker tracker = new();

    // Idle rates in percent, changed by the main sequence as the run moves on.
    int send_idle_pct = 19;
    int recv_idle_pct = 62;

    // Grid size currently programmed, used to aim random coordinates at the grid.
    int grid_w_cfg = GRID_WIDTH_RST;
    int grid_h_cfg = GRID_HEIGHT_RST;

    // Recently written cells, so that reads often land on cells with known content.
    logic [2*COORD_W-1:0] written_cells [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sends one command word. Valid stays high on return, so that a following word can go
    // out on the very next cycle; idle cycles lower it first.
    task automatic send_command(input logic func, input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y, input logic [TYPE_BITS-1:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.func     <= func;
        cmd_if.cell_x   <= x;
        cmd_if.cell_y   <= y;
        cmd_if.new_type <= t;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        tracker.take_command(func, x, y, t);
    endtask

    // One APB setup and access pair. psel is left high so that a second write can follow
    // directly; the caller closes the transfer.
    task automatic write_register(input logic reg_sel, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({reg_sel, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.set_dimension(reg_sel, value);
    endtask

    // The grid size may only change while the block is idle, so the command channel is
    // parked and every queued response is collected first.
    task automatic set_grid(input int w, input int h);
        cmd_if.valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        write_register(REG_GRID_WIDTH, APB_DATA_W'(w));
        write_register(REG_GRID_HEIGHT, APB_DATA_W'(h));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        grid_w_cfg = w & 32'h1FFF;
        grid_h_cfg = h & 32'h1FFF;
    endtask

    function automatic logic [COORD_W-1:0] clamp_coord(input int v);
        if (v < 0) return '0;
        if (v > 4095) return '1;
        return COORD_W'(v);
    endfunction

    // A coordinate on or just past a grid edge, or at the ends of the field.
    function automatic logic [COORD_W-1:0] edge_coord(input int dim);
        case ($urandom_range(3))
            0: return '0;
            1: return clamp_coord(dim - 1);
            2: return clamp_coord(dim);
            default: return '1;
        endcase
    endfunction

    // Random command: most land inside the grid or on recently written cells, the rest
    // probe the edges and the whole coordinate space.
    task automatic random_command();
        logic                 func;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [TYPE_BITS-1:0] t;
        int                   mode;
        int                   xmax;
        int                   ymax;
        int                   rows;
        logic [2*COORD_W-1:0] picked;
        func = ($urandom_range(99) < 45) ? FUNC_WRITE : FUNC_READ;
        t    = TYPE_BITS'($urandom);
        mode = $urandom_range(99);
        if (mode < 20 && written_cells.size() > 0) begin
            picked = written_cells[$urandom_range(written_cells.size() - 1)];
            x      = picked[2*COORD_W-1:COORD_W];
            y      = picked[COORD_W-1:0];
        end else if (mode < 70 && grid_w_cfg > 0 && grid_h_cfg > 0) begin
            // Rows past the store's capacity are left mostly to the other modes, but
            // the last partial row is included so the capacity edge gets hit.
            xmax = ((grid_w_cfg < 4096) ? grid_w_cfg : 4096) - 1;
            rows = (MAX_CELLS + grid_w_cfg - 1) / grid_w_cfg;
            ymax = ((grid_h_cfg < rows) ? grid_h_cfg : rows) - 1;
            x    = COORD_W'($urandom_range(xmax));
            y    = COORD_W'($urandom_range(ymax));
        end else if (mode < 82) begin
            x = edge_coord(grid_w_cfg);
            y = edge_coord(grid_h_cfg);
        end else begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
        end
        if (func == FUNC_WRITE) begin
            written_cells.push_back({x, y});
            if (written_cells.size() > RECENT_CELLS) void'(written_cells.pop_front());
        end
        send_command(func, x, y, t);
    endtask

    // Response side: a word is checked at the edge that accepts it, and ready is redrawn
    // every cycle from the current idle rate.
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                tracker.check_response('{cell_type: rsp_if.cell_type,
                                         passable:  rsp_if.passable,
                                         wall:      rsp_if.wall,
                                         water:     rsp_if.water,
                                         quicksand: rsp_if.quicksand,
                                         in_bounds: rsp_if.in_bounds});
            end
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on quiet cycles across all three ports.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)
                    || (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= QUIET_LIMIT) begin
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        int phase_w [NUM_PHASES];
        int phase_h [NUM_PHASES];
        cmd_if.valid    <= 1'b0;
        cmd_if.func     <= FUNC_READ;
        cmd_if.cell_x   <= '0;
        cmd_if.cell_y   <= '0;
        cmd_if.new_type <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        i_rst_n         <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on the reset grid of 64 by 64. Every cell starts as wall; the
        // write followed at once by a read of the same cell checks the type just written.
        send_command(FUNC_READ,  12'd0,    12'd0,    3'd0);
        send_command(FUNC_WRITE, 12'd0,    12'd0,    3'd0);
        send_command(FUNC_READ,  12'd0,    12'd0,    3'd5);
        send_command(FUNC_WRITE, 12'd1,    12'd0,    3'd1);
        send_command(FUNC_WRITE, 12'd2,    12'd0,    3'd2);
        send_command(FUNC_WRITE, 12'd3,    12'd0,    3'd3);
        send_command(FUNC_WRITE, 12'd4,    12'd0,    3'd4);
        send_command(FUNC_WRITE, 12'd5,    12'd0,    3'd5);
        send_command(FUNC_WRITE, 12'd6,    12'd0,    3'd6);
        // Cell 10 straddles bit 32 of its 48-bit row; cell 21 lies in the second row.
        send_command(FUNC_WRITE, 12'd10,   12'd0,    3'd5);
        send_command(FUNC_READ,  12'd10,   12'd0,    3'd0);
        send_command(FUNC_READ,  12'd9,    12'd0,    3'd0);
        send_command(FUNC_READ,  12'd11,   12'd0,    3'd0);
        send_command(FUNC_WRITE, 12'd21,   12'd0,    3'd2);
        send_command(FUNC_READ,  12'd21,   12'd0,    3'd7);
        send_command(FUNC_WRITE, 12'd63,   12'd63,   3'd3);
        send_command(FUNC_READ,  12'd63,   12'd63,   3'd0);
        // Outside the grid: writes are dropped and reads give wall.
        send_command(FUNC_WRITE, 12'd64,   12'd0,    3'd1);
        send_command(FUNC_READ,  12'd64,   12'd0,    3'd0);
        send_command(FUNC_WRITE, 12'd0,    12'd64,   3'd1);
        send_command(FUNC_READ,  12'd4095, 12'd4095, 3'd0);
        send_command(FUNC_WRITE, 12'd4095, 12'd4095, 3'd0);
        send_command(FUNC_WRITE, 12'd1,    12'd0,    3'd7);
        send_command(FUNC_READ,  12'd1,    12'd0,    3'd0);
        send_command(FUNC_READ,  12'd6,    12'd0,    3'd0);

        // Grid settings: the reset size, the smallest, sizes past the capacity, zero
        // width or height, the largest register value and a few ordinary shapes.
        phase_w = '{64, 1, 4096, 0, 64, 8191, 100, 4096, 1, 13, 0, 0};
        phase_h = '{64, 1, 4096, 64, 0, 8191, 50, 1, 4096, 7, 0, 0};
        phase_w[10] = $urandom_range(1, 4096);
        phase_h[10] = $urandom_range(1, 4096);
        phase_w[11] = $urandom_range(1, 200);
        phase_h[11] = $urandom_range(1, 200);

        for (int p = 0; p < NUM_PHASES; p++) begin
            // First the sender idles lightly and the receiver heavily, then the other
            // way round, then neither idles.
            if (p < NUM_PHASES / 3) begin
                send_idle_pct = 19;
                recv_idle_pct = 62;
            end else if (p < 2 * NUM_PHASES / 3) begin
                send_idle_pct = 62;
                recv_idle_pct = 19;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_grid(phase_w[p], phase_h[p]);
            written_cells.delete();
            for (int i = 0; i < PHASE_ITEMS; i++) random_command();
        end

        cmd_if.valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        // A drain period catches any stray response word after the last one expected.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
